// ===== design/cp_autocorr_sync_detector_top_assert.svh =====
// ----------------------------------------------------------------------------
// cp autocorrelation sync detector - assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CP_AUTOCORR_SYNC_DETECTOR_TOP_ASSERT_SVH
`define CP_AUTOCORR_SYNC_DETECTOR_TOP_ASSERT_SVH

// property checked outside reset
`define CPAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also covers the reset cycles
`define CPAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cpac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpac_pkg
// Shared constants, codes and types of the cp autocorrelation sync detector.
// ----------------------------------------------------------------------------
package cpac_pkg;

  localparam int SYMBOL_LEN_DEF   = 160;
  localparam int BODY_LEN_DEF     = 128;
  localparam int PREFIX_LEN_DEF   = 32;
  localparam int STORE_LEN_DEF    = 480;
  localparam int ROTATE_SHIFT_DEF = 40;

  localparam int CFG_W = 16;

  localparam logic [15:0] SMOOTH_COEFF_RST     = 16'd62259;
  localparam logic [15:0] SIGNAL_THRESHOLD_RST = 16'd12452;
  localparam logic [11:0] SINE_RATIO_RST       = 12'd1024;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_CLEAR     = 2'd1,
    CMD_ROT_LEFT  = 2'd2,
    CMD_ROT_RIGHT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SMOOTH_COEFF     = 2'd0,
    REG_SIGNAL_THRESHOLD = 2'd1,
    REG_SINE_RATIO       = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic store_sample;
    logic sm_clear;
    logic rot_left;
    logic rot_right;
    logic acc_clr;
    logic issue;
    logic div_start;
    logic div_im;
    logic cap_re;
    logic cap_im;
    logic sm_mul;
    logic sm_sum;
    logic wb;
    logic cmp;
    logic first;
    logic sq_start;
    logic sq_min;
    logic cap_pk;
    logic cap_mn;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } dp_status_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) begin
      sat16 = 16'sd32767;
    end else if (v < -36'sd32768) begin
      sat16 = -16'sd32768;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage

// ===== design/cp_autocorr_sync_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp_autocorr_sync_detector_top
// Cyclic-prefix autocorrelation timing and signal detector.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | command, sample_re, sample_im, block_end
//  out      | out_valid / out_ready| peak_offset, peak/min magnitude, peak_re/im,
//           |                      | signal_detected, sine_detected
//  cfg      | cfg_we               | cfg_index, cfg_data
//
// A block end runs the correlation for every offset in turn: the MAC steps,
// a division of the real and then of the imaginary part and the smoothing and
// search steps, through the single MAC lane and the shared divider. Reset is
// synchronous and needs no clearing pass. A waiting result does not stop
// further transactions, only the hand-off of the next result.
// ----------------------------------------------------------------------------
module cp_autocorr_sync_detector_top
  import cpac_pkg::*;
#(
  parameter int SYMBOL_LEN   = SYMBOL_LEN_DEF,
  parameter int BODY_LEN     = BODY_LEN_DEF,
  parameter int PREFIX_LEN   = PREFIX_LEN_DEF,
  parameter int STORE_LEN    = STORE_LEN_DEF,
  parameter int ROTATE_SHIFT = ROTATE_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [15:0] sample_re,
  input  logic signed [15:0] sample_im,
  input  logic               block_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         peak_offset,
  output logic [15:0]        peak_magnitude,
  output logic [15:0]        min_magnitude,
  output logic signed [15:0] peak_re,
  output logic signed [15:0] peak_im,
  output logic               signal_detected,
  output logic               sine_detected,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  dp_cmd_t                         cmd;
  dp_status_t                      status;
  logic [$clog2(SYMBOL_LEN)-1:0]   g;
  logic [$clog2(PREFIX_LEN+2)-1:0] k;

  cpac_ctrl #(
    .SYMBOL_LEN (SYMBOL_LEN),
    .PREFIX_LEN (PREFIX_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .block_end (block_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd),
    .g         (g),
    .k         (k)
  );

  cpac_dp #(
    .SYMBOL_LEN   (SYMBOL_LEN),
    .BODY_LEN     (BODY_LEN),
    .PREFIX_LEN   (PREFIX_LEN),
    .STORE_LEN    (STORE_LEN),
    .ROTATE_SHIFT (ROTATE_SHIFT)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .g               (g),
    .k               (k),
    .sample_re       (sample_re),
    .sample_im       (sample_im),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .peak_offset     (peak_offset),
    .peak_magnitude  (peak_magnitude),
    .min_magnitude   (min_magnitude),
    .peak_re         (peak_re),
    .peak_im         (peak_im),
    .signal_detected (signal_detected),
    .sine_detected   (sine_detected)
  );

endmodule

// ===== design/cpac_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpac_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/cpac_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpac_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module cpac_div #(
  parameter int NUM_W = 66,
  parameter int DEN_W = 40,
  parameter int Q_W   = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             done
);

  localparam int DIV_W = DEN_W + Q_W;
  localparam int CNT_W = $clog2(Q_W);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dv;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  // caller guarantees num < den * 2**Q_W
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(Q_W - 1);
      rem  <= DIV_W'(num);
      dv   <= DIV_W'(den) << (Q_W - 1);
      quo  <= '0;
    end else if (busy) begin
      if (rem >= dv) begin
        rem <= rem - dv;
        quo <= {quo[Q_W-2:0], 1'b1};
      end else begin
        quo <= {quo[Q_W-2:0], 1'b0};
      end
      dv <= dv >> 1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== design/cpac_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpac_sqrt
// Integer square root of a 32 bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module cpac_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x,
  output logic [15:0] root,
  output logic        done
);

  logic [31:0] rem;
  logic [31:0] res;
  logic [31:0] bitv;
  logic [3:0]  cnt;
  logic        busy;
  logic [31:0] trial;

  assign trial = res + bitv;
  assign root  = res[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= 4'd15;
      rem  <= x;
      res  <= '0;
      bitv <= 32'h4000_0000;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== design/cpac_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpac_ctrl
// Sequencer: sample/command handling, per-offset correlation loop, peak and
// minimum root extraction and result hand-off.
// ----------------------------------------------------------------------------
module cpac_ctrl
  import cpac_pkg::*;
#(
  parameter int SYMBOL_LEN = SYMBOL_LEN_DEF,
  parameter int PREFIX_LEN = PREFIX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic                          block_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  dp_status_t                    status,
  output dp_cmd_t                       cmd,
  output logic [$clog2(SYMBOL_LEN)-1:0] g,
  output logic [$clog2(PREFIX_LEN+2)-1:0] k
);

  localparam int G_W = $clog2(SYMBOL_LEN);
  localparam int K_W = $clog2(PREFIX_LEN + 2);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_DIV_RE_GO,
    S_DIV_RE_WAIT,
    S_DIV_IM_GO,
    S_DIV_IM_WAIT,
    S_SM_MUL,
    S_SM_SUM,
    S_WB,
    S_CMP,
    S_SQ_PK_GO,
    S_SQ_PK_WAIT,
    S_SQ_MN_GO,
    S_SQ_MN_WAIT,
    S_LOAD
  } state_t;

  state_t state;
  logic   acc;
  logic   can_load;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign can_load = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (command)
            CMD_SAMPLE:    cmd.store_sample = 1'b1;
            CMD_CLEAR:     cmd.sm_clear     = 1'b1;
            CMD_ROT_LEFT:  cmd.rot_left     = 1'b1;
            CMD_ROT_RIGHT: cmd.rot_right    = 1'b1;
            default: ;
          endcase
        end
      end
      S_MAC: begin
        cmd.acc_clr = (k == '0);
        cmd.issue   = (k < K_W'(PREFIX_LEN));
      end
      S_DIV_RE_GO:   cmd.div_start = 1'b1;
      S_DIV_RE_WAIT: cmd.cap_re    = status.div_done;
      S_DIV_IM_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_im    = 1'b1;
      end
      S_DIV_IM_WAIT: cmd.cap_im = status.div_done;
      S_SM_MUL:      cmd.sm_mul = 1'b1;
      S_SM_SUM:      cmd.sm_sum = 1'b1;
      S_WB:          cmd.wb     = 1'b1;
      S_CMP: begin
        cmd.cmp   = 1'b1;
        cmd.first = (g == '0);
      end
      S_SQ_PK_GO:    cmd.sq_start = 1'b1;
      S_SQ_PK_WAIT:  cmd.cap_pk   = status.sqrt_done;
      S_SQ_MN_GO: begin
        cmd.sq_start = 1'b1;
        cmd.sq_min   = 1'b1;
      end
      S_SQ_MN_WAIT:  cmd.cap_mn   = status.sqrt_done;
      S_LOAD:        cmd.out_load = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      g         <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc && command == CMD_SAMPLE && block_end) begin
            g     <= '0;
            k     <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          // the last k steps issue no read and drain the read and product stages
          if (k == K_W'(PREFIX_LEN + 1)) begin
            k     <= '0;
            state <= S_DIV_RE_GO;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DIV_RE_GO:   state <= S_DIV_RE_WAIT;
        S_DIV_RE_WAIT: if (status.div_done) state <= S_DIV_IM_GO;
        S_DIV_IM_GO:   state <= S_DIV_IM_WAIT;
        S_DIV_IM_WAIT: if (status.div_done) state <= S_SM_MUL;
        S_SM_MUL:      state <= S_SM_SUM;
        S_SM_SUM:      state <= S_WB;
        S_WB:          state <= S_CMP;
        S_CMP: begin
          if (g == G_W'(SYMBOL_LEN - 1)) begin
            state <= S_SQ_PK_GO;
          end else begin
            g     <= g + 1'b1;
            state <= S_MAC;
          end
        end
        S_SQ_PK_GO:    state <= S_SQ_PK_WAIT;
        S_SQ_PK_WAIT:  if (status.sqrt_done) state <= S_SQ_MN_GO;
        S_SQ_MN_GO:    state <= S_SQ_MN_WAIT;
        S_SQ_MN_WAIT:  if (status.sqrt_done) state <= S_LOAD;
        S_LOAD:        if (can_load) state <= S_IDLE;
        default:       state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/cpac_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpac_dp
// Datapath: circular sample store, correlation MAC, normalising divider,
// IIR smoothing with rotatable smoothed store, peak/min search, result regs.
// ----------------------------------------------------------------------------
module cpac_dp
  import cpac_pkg::*;
#(
  parameter int SYMBOL_LEN   = SYMBOL_LEN_DEF,
  parameter int BODY_LEN     = BODY_LEN_DEF,
  parameter int PREFIX_LEN   = PREFIX_LEN_DEF,
  parameter int STORE_LEN    = STORE_LEN_DEF,
  parameter int ROTATE_SHIFT = ROTATE_SHIFT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dp_cmd_t                         cmd,
  output dp_status_t                      status,
  input  logic [$clog2(SYMBOL_LEN)-1:0]   g,
  input  logic [$clog2(PREFIX_LEN+2)-1:0] k,
  input  logic signed [15:0]              sample_re,
  input  logic signed [15:0]              sample_im,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [CFG_W-1:0]                cfg_data,
  output logic [7:0]                      peak_offset,
  output logic [15:0]                     peak_magnitude,
  output logic [15:0]                     min_magnitude,
  output logic signed [15:0]              peak_re,
  output logic signed [15:0]              peak_im,
  output logic                            signal_detected,
  output logic                            sine_detected
);

  localparam int SA_W   = $clog2(STORE_LEN);
  localparam int CNT_W  = $clog2(STORE_LEN + 1);
  localparam int SM_W   = $clog2(SYMBOL_LEN);
  localparam int L_W    = $clog2(2*SYMBOL_LEN + BODY_LEN + PREFIX_LEN + 2*STORE_LEN) + 1;
  localparam int P_LOG  = $clog2(PREFIX_LEN + 1);
  localparam int ACC_W  = 34 + P_LOG;
  localparam int D_W    = 34 + P_LOG;
  localparam int Q_W    = 17;
  localparam int NUM_W  = ACC_W + 16;
  localparam int BASE0  = SYMBOL_LEN - PREFIX_LEN;
  localparam int SH_L   = ROTATE_SHIFT % SYMBOL_LEN;
  localparam int SH_R   = (SYMBOL_LEN - SH_L) % SYMBOL_LEN;

  // configuration
  logic [15:0] smooth_coeff;
  logic [15:0] signal_threshold;
  logic [11:0] sine_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_coeff     <= SMOOTH_COEFF_RST;
      signal_threshold <= SIGNAL_THRESHOLD_RST;
      sine_ratio       <= SINE_RATIO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SMOOTH_COEFF:     smooth_coeff     <= cfg_data[15:0];
        REG_SIGNAL_THRESHOLD: signal_threshold <= cfg_data[15:0];
        REG_SINE_RATIO:       sine_ratio       <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // sample store: circular buffer, wp points at the oldest entry
  logic [SA_W-1:0]  wp;
  logic [CNT_W-1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (cmd.store_sample) begin
      wp <= (wp == SA_W'(STORE_LEN - 1)) ? '0 : wp + 1'b1;
      if (fill != CNT_W'(STORE_LEN)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // logical index to {zero, physical address}; never-written and outside reads are zero
  function automatic logic [SA_W:0] map_idx(input logic signed [L_W-1:0] l,
                                            input logic [SA_W-1:0] p,
                                            input logic [CNT_W-1:0] n);
    logic [L_W-1:0] lu;
    logic [SA_W:0]  s;
    logic           z;
    lu = l;
    z  = l[L_W-1] || (lu >= L_W'(STORE_LEN)) || ((lu + L_W'(n)) < L_W'(STORE_LEN));
    s  = {1'b0, p} + (SA_W+1)'(lu);
    if (s >= (SA_W+1)'(STORE_LEN)) begin
      s = s - (SA_W+1)'(STORE_LEN);
    end
    map_idx = {z, s[SA_W-1:0]};
  endfunction

  logic signed [L_W-1:0] la;
  logic signed [L_W-1:0] lb;
  logic [SA_W:0]         ma;
  logic [SA_W:0]         mb;

  assign la = L_W'(BASE0) + L_W'(g) + L_W'(k);
  assign lb = la + L_W'(BODY_LEN);
  assign ma = map_idx(la, wp, fill);
  assign mb = map_idx(lb, wp, fill);

  logic [31:0] ram_a_q;
  logic [31:0] ram_b_q;

  cpac_ram #(.WIDTH(32), .DEPTH(STORE_LEN)) u_ram_a (
    .clk   (clk),
    .we    (cmd.store_sample),
    .waddr (wp),
    .wdata ({sample_re, sample_im}),
    .re    (cmd.issue),
    .raddr (ma[SA_W-1:0]),
    .rdata (ram_a_q)
  );

  cpac_ram #(.WIDTH(32), .DEPTH(STORE_LEN)) u_ram_b (
    .clk   (clk),
    .we    (cmd.store_sample),
    .waddr (wp),
    .wdata ({sample_re, sample_im}),
    .re    (cmd.issue),
    .raddr (mb[SA_W-1:0]),
    .rdata (ram_b_q)
  );

  // correlation pipeline: read, product, accumulate
  logic rd_v;
  logic prod_v;
  logic za_q;
  logic zb_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v   <= cmd.issue;
      prod_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      za_q <= ma[SA_W];
      zb_q <= mb[SA_W];
    end
  end

  logic signed [15:0] a_re;
  logic signed [15:0] a_im;
  logic signed [15:0] b_re;
  logic signed [15:0] b_im;

  assign a_re = za_q ? '0 : ram_a_q[31:16];
  assign a_im = za_q ? '0 : ram_a_q[15:0];
  assign b_re = zb_q ? '0 : ram_b_q[31:16];
  assign b_im = zb_q ? '0 : ram_b_q[15:0];

  logic signed [31:0] p_rr1, p_rr2, p_ri1, p_ri2;
  logic signed [31:0] p_ea1, p_ea2, p_eb1, p_eb2;

  always_ff @(posedge clk) begin
    if (rd_v) begin
      p_rr1 <= a_re * b_re;
      p_rr2 <= a_im * b_im;
      p_ri1 <= a_im * b_re;
      p_ri2 <= a_re * b_im;
      p_ea1 <= a_re * a_re;
      p_ea2 <= a_im * a_im;
      p_eb1 <= b_re * b_re;
      p_eb2 <= b_im * b_im;
    end
  end

  logic signed [ACC_W-1:0] rr;
  logic signed [ACC_W-1:0] ri;
  logic [D_W-1:0]          den;

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      rr  <= '0;
      ri  <= '0;
      den <= '0;
    end else if (prod_v) begin
      rr  <= rr + ACC_W'(p_rr1) + ACC_W'(p_rr2);
      ri  <= ri + ACC_W'(p_ri1) - ACC_W'(p_ri2);
      den <= den + D_W'($unsigned(p_ea1)) + D_W'($unsigned(p_ea2))
                 + D_W'($unsigned(p_eb1)) + D_W'($unsigned(p_eb2));
    end
  end

  // normalisation: round(|r| * 65536 / d), |r| <= d/2 keeps the quotient in Q_W bits
  logic [ACC_W-1:0] r_sel;
  logic             r_neg;
  logic [ACC_W-1:0] r_mag;
  logic [NUM_W-1:0] num;
  logic [Q_W-1:0]   quo;
  logic             q_neg;
  logic             div_done;

  assign r_sel = cmd.div_im ? ri : rr;
  assign r_neg = r_sel[ACC_W-1];
  assign r_mag = r_neg ? (~r_sel + 1'b1) : r_sel;
  assign num   = {r_mag, 16'b0} + NUM_W'(den >> 1);

  cpac_div #(.NUM_W(NUM_W), .DEN_W(D_W), .Q_W(Q_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .quo   (quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q_neg <= r_neg;
    end
  end

  logic signed [15:0] nr;
  logic signed [15:0] ni;
  logic signed [15:0] n_val;

  assign n_val = (den == '0) ? '0 : sat16(q_neg ? -36'(quo) : 36'(quo));

  always_ff @(posedge clk) begin
    if (cmd.cap_re) begin
      nr <= n_val;
    end
    if (cmd.cap_im) begin
      ni <= n_val;
    end
  end

  // smoothed store, addressed through a rotation offset
  logic [SM_W-1:0]       rot;
  logic [SM_W:0]         rot_sum;
  logic [SM_W:0]         sa_sum;
  logic [SM_W-1:0]       sa_comb;
  logic [SM_W-1:0]       sm_addr;
  logic [SYMBOL_LEN-1:0] sm_valid;
  logic                  sm_vld_q;
  logic [31:0]           sm_q;

  assign rot_sum = {1'b0, rot} + (SM_W+1)'(cmd.rot_left ? SH_L : SH_R);
  assign sa_sum  = {1'b0, g} + {1'b0, rot};
  assign sa_comb = (sa_sum >= (SM_W+1)'(SYMBOL_LEN)) ?
                   SM_W'(sa_sum - (SM_W+1)'(SYMBOL_LEN)) : sa_sum[SM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rot      <= '0;
      sm_valid <= '0;
    end else begin
      if (cmd.rot_left || cmd.rot_right) begin
        rot <= (rot_sum >= (SM_W+1)'(SYMBOL_LEN)) ?
               SM_W'(rot_sum - (SM_W+1)'(SYMBOL_LEN)) : rot_sum[SM_W-1:0];
      end
      if (cmd.sm_clear) begin
        sm_valid <= '0;
      end else if (cmd.wb) begin
        sm_valid[sm_addr] <= 1'b1;
      end
    end
  end

  logic signed [15:0] new_re;
  logic signed [15:0] new_im;

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      sm_addr  <= sa_comb;
      sm_vld_q <= sm_valid[sa_comb];
    end
  end

  cpac_ram #(.WIDTH(32), .DEPTH(SYMBOL_LEN)) u_ram_sm (
    .clk   (clk),
    .we    (cmd.wb),
    .waddr (sm_addr),
    .wdata ({new_re, new_im}),
    .re    (cmd.acc_clr),
    .raddr (sa_comb),
    .rdata (sm_q)
  );

  // iir: s' = round((c*s + (65536-c)*n) / 65536)
  logic signed [15:0] s_re;
  logic signed [15:0] s_im;
  logic signed [16:0] c_s;
  logic signed [17:0] cm_s;
  logic signed [33:0] m1_re, m2_re, m1_im, m2_im;

  assign s_re = sm_vld_q ? sm_q[31:16] : '0;
  assign s_im = sm_vld_q ? sm_q[15:0]  : '0;
  assign c_s  = {1'b0, smooth_coeff};
  assign cm_s = 18'h10000 - {2'b0, smooth_coeff};

  function automatic logic signed [15:0] rnd16(input logic signed [34:0] s);
    logic signed [34:0] a;
    logic signed [34:0] v;
    a = -s;
    if (s >= 0) begin
      v = (s + 35'sd32768) >>> 16;
    end else begin
      v = -((a + 35'sd32768) >>> 16);
    end
    rnd16 = sat16(36'(v));
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.sm_mul) begin
      m1_re <= c_s * s_re;
      m2_re <= cm_s * nr;
      m1_im <= c_s * s_im;
      m2_im <= cm_s * ni;
    end
    if (cmd.sm_sum) begin
      new_re <= rnd16(35'(m1_re) + 35'(m2_re));
      new_im <= rnd16(35'(m1_im) + 35'(m2_im));
    end
  end

  // peak and minimum search, one offset per pass
  logic signed [31:0] sq_re;
  logic signed [31:0] sq_im;
  logic [31:0]        sq_sum;
  logic [31:0]        best_sq;
  logic [31:0]        min_sq;
  logic [SM_W-1:0]    best_g;
  logic signed [15:0] best_re;
  logic signed [15:0] best_im;

  assign sq_sum = $unsigned(sq_re) + $unsigned(sq_im);

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      sq_re <= new_re * new_re;
      sq_im <= new_im * new_im;
    end
    if (cmd.cmp) begin
      if (cmd.first || sq_sum > best_sq) begin
        best_sq <= sq_sum;
        best_g  <= g;
        best_re <= new_re;
        best_im <= new_im;
      end
      if (cmd.first || sq_sum < min_sq) begin
        min_sq <= sq_sum;
      end
    end
  end

  logic [15:0] root;
  logic        sqrt_done;
  logic [15:0] root_sat;
  logic [15:0] pk;
  logic [15:0] mn;

  cpac_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sq_start),
    .x     (cmd.sq_min ? min_sq : best_sq),
    .root  (root),
    .done  (sqrt_done)
  );

  assign root_sat = (root > 16'd32768) ? 16'd32768 : root;

  always_ff @(posedge clk) begin
    if (cmd.cap_pk) begin
      pk <= root_sat;
    end
    if (cmd.cap_mn) begin
      mn <= root_sat;
    end
  end

  assign status.div_done  = div_done;
  assign status.sqrt_done = sqrt_done;

  // result register
  logic [27:0] ratio_mn;

  assign ratio_mn = sine_ratio * mn;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      peak_offset     <= 8'(best_g);
      peak_magnitude  <= pk;
      min_magnitude   <= mn;
      peak_re         <= best_re;
      peak_im         <= best_im;
      signal_detected <= (pk > signal_threshold);
      if (pk == '0 && mn == '0) begin
        sine_detected <= (sine_ratio != '0);
      end else begin
        sine_detected <= (28'({pk, 8'b0}) < ratio_mn);
      end
    end
  end

endmodule

// ===== design/cpac_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpac_checker
// Port-level checks of the cp autocorrelation sync detector.
// ----------------------------------------------------------------------------
`include "cp_autocorr_sync_detector_top_assert.svh"

module cpac_checker
  import cpac_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         command,
  input logic signed [15:0] sample_re,
  input logic signed [15:0] sample_im,
  input logic               block_end,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         peak_offset,
  input logic [15:0]        peak_magnitude,
  input logic [15:0]        min_magnitude,
  input logic signed [15:0] peak_re,
  input logic signed [15:0] peak_im,
  input logic               signal_detected,
  input logic               sine_detected,
  input logic               cfg_we,
  input logic [1:0]         cfg_index,
  input logic [CFG_W-1:0]   cfg_data
);

  // shadow of the signal threshold as written through the config port
  logic [15:0] thr_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_q <= SIGNAL_THRESHOLD_RST;
    end else if (cfg_we && cfg_index == REG_SIGNAL_THRESHOLD) begin
      thr_q <= cfg_data[15:0];
    end
  end

  `CPAC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `CPAC_ASSERT(a_mag_order, out_valid |-> min_magnitude <= peak_magnitude && peak_magnitude <= 16'd32768, "magnitude order broken")
  `CPAC_ASSERT(a_sig_flag, out_valid |-> signal_detected == (peak_magnitude > thr_q), "signal flag mismatch")
  `CPAC_ASSERT_ALWAYS(a_rst_quiet, rst |=> !out_valid, "result shown after reset")

endmodule

bind cp_autocorr_sync_detector_top cpac_checker u_cpac_checker (.*);
